>>> hw/rtl/segment_intersection_classifier_core_assert.svh
// Assertion macros shared by the segment intersection classifier RTL.
`ifndef SEGMENT_INTERSECTION_CLASSIFIER_CORE_ASSERT_SVH
`define SEGMENT_INTERSECTION_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication; the consequent may be a sequence with a fixed delay.
`define SIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("next-cycle check failed");

`endif

>>> hw/rtl/sic_pkg.sv
// Package with widths, types and the classification table of the classifier.
`timescale 1ns / 1ps

package sic_pkg;

    // Width of each coordinate port and its significant low bits.
    localparam int PORT_W     = 32;
    localparam int COORD_BITS = 32;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    // Sign of a doubled area, encoded as sign plus one.
    typedef enum logic [1:0] {
        SIGN_NEG  = 2'd0,
        SIGN_ZERO = 2'd1,
        SIGN_POS  = 2'd2
    } sign_t;

    // Result codes.
    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_CROSS  = 3'd1,
        K_BD_END = 3'd2,
        K_AC_END = 3'd3,
        K_SHARED = 3'd4,
        K_COINC  = 3'd5,
        K_COLLIN = 3'd6,
        K_IMPOSS = 3'd7
    } kind_t;

    // Row is sign(A), sign(C); column is sign(B), sign(D).
    localparam kind_t KIND_TABLE [81] = '{
        K_CROSS,  K_BD_END, K_NONE,  K_BD_END, K_IMPOSS, K_IMPOSS, K_NONE,  K_IMPOSS, K_IMPOSS,
        K_AC_END, K_SHARED, K_NONE,  K_SHARED, K_IMPOSS, K_IMPOSS, K_NONE,  K_IMPOSS, K_IMPOSS,
        K_NONE,   K_NONE,   K_NONE,  K_NONE,   K_COINC,  K_NONE,   K_NONE,  K_NONE,   K_NONE,
        K_AC_END, K_SHARED, K_NONE,  K_SHARED, K_IMPOSS, K_IMPOSS, K_NONE,  K_IMPOSS, K_IMPOSS,
        K_IMPOSS, K_IMPOSS, K_COINC, K_IMPOSS, K_COLLIN, K_IMPOSS, K_COINC, K_IMPOSS, K_IMPOSS,
        K_IMPOSS, K_IMPOSS, K_NONE,  K_IMPOSS, K_IMPOSS, K_SHARED, K_NONE,  K_SHARED, K_AC_END,
        K_NONE,   K_NONE,   K_NONE,  K_NONE,   K_COINC,  K_NONE,   K_NONE,  K_NONE,   K_NONE,
        K_IMPOSS, K_IMPOSS, K_NONE,  K_IMPOSS, K_IMPOSS, K_SHARED, K_NONE,  K_SHARED, K_AC_END,
        K_IMPOSS, K_IMPOSS, K_NONE,  K_IMPOSS, K_IMPOSS, K_BD_END, K_NONE,  K_BD_END, K_CROSS
    };

    // Table index from the four area signs.
    function automatic logic [6:0] table_index(sign_t sa, sign_t sb, sign_t sc, sign_t sd);
        logic [6:0] idx;
        idx = 7'(27 * int'(sa)) + 7'(9 * int'(sc)) + 7'(3 * int'(sb)) + 7'(sd);
        return idx;
    endfunction

endpackage

>>> hw/rtl/sic_area_sign.sv
// Three-stage pipeline that finds the sign of the doubled area of triangle p q r.
`timescale 1ns / 1ps

module sic_area_sign (
    input  logic            clk,
    input  sic_pkg::point_t p,
    input  sic_pkg::point_t q,
    input  sic_pkg::point_t r,
    output sic_pkg::sign_t  sign
);

    logic signed [sic_pkg::DIFF_W-1:0] ux_reg, uy_reg, vx_reg, vy_reg;
    logic signed [sic_pkg::DIFF_W-1:0] ux_next, uy_next, vx_next, vy_next;
    logic signed [sic_pkg::PROD_W-1:0] left_reg, right_reg;
    logic signed [sic_pkg::PROD_W-1:0] left_next, right_next;
    sic_pkg::sign_t                    sign_reg, sign_next;

    // Stage one: edge vectors from p, one bit wider than a coordinate.
    always_comb
    begin
        ux_next = sic_pkg::DIFF_W'(q.x) - sic_pkg::DIFF_W'(p.x);
        uy_next = sic_pkg::DIFF_W'(q.y) - sic_pkg::DIFF_W'(p.y);
        vx_next = sic_pkg::DIFF_W'(r.x) - sic_pkg::DIFF_W'(p.x);
        vy_next = sic_pkg::DIFF_W'(r.y) - sic_pkg::DIFF_W'(p.y);
    end

    // Stage two: the two exact cross-product terms.
    always_comb
    begin
        left_next  = sic_pkg::PROD_W'(ux_reg) * sic_pkg::PROD_W'(vy_reg);
        right_next = sic_pkg::PROD_W'(uy_reg) * sic_pkg::PROD_W'(vx_reg);
    end

    // Stage three: compare the terms to get the area sign.
    always_comb
    begin
        if (left_reg > right_reg)
        begin
            sign_next = sic_pkg::SIGN_POS;
        end
        else if (left_reg == right_reg)
        begin
            sign_next = sic_pkg::SIGN_ZERO;
        end
        else
        begin
            sign_next = sic_pkg::SIGN_NEG;
        end
    end

    // Payload registers carry no reset; the valid chain lives in the top level.
    always_ff @(posedge clk)
    begin
        ux_reg    <= ux_next;
        uy_reg    <= uy_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        sign_reg  <= sign_next;
    end

    assign sign = sign_reg;

endmodule

>>> hw/rtl/segment_intersection_classifier_core.sv
// Throughput: one transaction per cycle; busy is always low and start is never refused.
// The depth is set by the edge-vector, multiply, compare and table-lookup stages.
// Reset clears the valid chain, so no done strobe follows reset; data is not reset.
// Results are strobed by done for one cycle, and the receiver cannot stall them.
`timescale 1ns / 1ps
`include "segment_intersection_classifier_core_assert.svh"

module segment_intersection_classifier_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sic_pkg::PORT_W-1:0]  a_x,
    input  logic [sic_pkg::PORT_W-1:0]  a_y,
    input  logic [sic_pkg::PORT_W-1:0]  c_x,
    input  logic [sic_pkg::PORT_W-1:0]  c_y,
    input  logic [sic_pkg::PORT_W-1:0]  b_x,
    input  logic [sic_pkg::PORT_W-1:0]  b_y,
    input  logic [sic_pkg::PORT_W-1:0]  d_x,
    input  logic [sic_pkg::PORT_W-1:0]  d_y,
    output logic                        done,
    output logic [2:0]                  kind
);

    sic_pkg::point_t pa, pb, pc, pd;
    sic_pkg::sign_t  sa, sb, sc, sd;
    logic            v1_reg, v2_reg, v3_reg, done_reg;
    sic_pkg::kind_t  kind_reg, kind_next;

    // The pipeline never stalls, so every start is taken.
    assign busy = 1'b0;

    // Only the low significant bits of each coordinate count.
    always_comb
    begin
        pa.x = sic_pkg::coord_t'(a_x[sic_pkg::COORD_BITS-1:0]);
        pa.y = sic_pkg::coord_t'(a_y[sic_pkg::COORD_BITS-1:0]);
        pb.x = sic_pkg::coord_t'(b_x[sic_pkg::COORD_BITS-1:0]);
        pb.y = sic_pkg::coord_t'(b_y[sic_pkg::COORD_BITS-1:0]);
        pc.x = sic_pkg::coord_t'(c_x[sic_pkg::COORD_BITS-1:0]);
        pc.y = sic_pkg::coord_t'(c_y[sic_pkg::COORD_BITS-1:0]);
        pd.x = sic_pkg::coord_t'(d_x[sic_pkg::COORD_BITS-1:0]);
        pd.y = sic_pkg::coord_t'(d_y[sic_pkg::COORD_BITS-1:0]);
    end

    // Four area units: A = bcd, B = cda, C = dab, D = abc.
    sic_area_sign u_area_a (.clk(clk), .p(pb), .q(pc), .r(pd), .sign(sa));
    sic_area_sign u_area_b (.clk(clk), .p(pc), .q(pd), .r(pa), .sign(sb));
    sic_area_sign u_area_c (.clk(clk), .p(pd), .q(pa), .r(pb), .sign(sc));
    sic_area_sign u_area_d (.clk(clk), .p(pa), .q(pb), .r(pc), .sign(sd));

    // Final stage: the sign pattern selects the result code.
    assign kind_next = sic_pkg::KIND_TABLE[sic_pkg::table_index(sa, sb, sc, sd)];

    // Valid bits travel alongside the area pipelines.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // Result code register.
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

    assign done = done_reg;
    assign kind = kind_reg;

    // Every accepted transaction yields exactly one result.
    `SIC_ASSERT_NEXT(a_accept_done, clk, rst_n, start && !busy, ##3 done)
    `SIC_ASSERT_IMPL(a_done_from_accept, clk, rst_n, done, $past(start && !busy, 4))
    // Four equal points give zero areas everywhere, which is the collinear case.
    `SIC_ASSERT_NEXT(a_all_equal_collinear, clk, rst_n,
        start && (pa == pb) && (pa == pc) && (pa == pd),
        ##3 (done && (kind_reg == sic_pkg::K_COLLIN)))

endmodule

>>> test/segment_pair_kind_checker.sv
// Checker that predicts and compares the intersection kind of each segment pair.
`timescale 1ns / 1ps

module segment_pair_kind_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [sic_pkg::PORT_W-1:0] a_x,
    input  logic [sic_pkg::PORT_W-1:0] a_y,
    input  logic [sic_pkg::PORT_W-1:0] c_x,
    input  logic [sic_pkg::PORT_W-1:0] c_y,
    input  logic [sic_pkg::PORT_W-1:0] b_x,
    input  logic [sic_pkg::PORT_W-1:0] b_y,
    input  logic [sic_pkg::PORT_W-1:0] d_x,
    input  logic [sic_pkg::PORT_W-1:0] d_y,
    input  logic                       done,
    input  logic [2:0]                 kind,
    output int                         mismatch_count,
    output int                         pending_count,
    output int                         checked_count,
    output logic [7:0]                 kinds_seen
);

    // Wide enough for a difference of two products of 33-bit differences.
    typedef logic signed [71:0] area_t;

    // Kind by area signs: row is sign of A then C, column is sign of B then D,
    // each sign encoded as negative, zero, positive.
    localparam sic_pkg::kind_t KIND_BY_SIGNS [81] = '{
        sic_pkg::K_CROSS,  sic_pkg::K_BD_END, sic_pkg::K_NONE,
        sic_pkg::K_BD_END, sic_pkg::K_IMPOSS, sic_pkg::K_IMPOSS,
        sic_pkg::K_NONE,   sic_pkg::K_IMPOSS, sic_pkg::K_IMPOSS,
        sic_pkg::K_AC_END, sic_pkg::K_SHARED, sic_pkg::K_NONE,
        sic_pkg::K_SHARED, sic_pkg::K_IMPOSS, sic_pkg::K_IMPOSS,
        sic_pkg::K_NONE,   sic_pkg::K_IMPOSS, sic_pkg::K_IMPOSS,
        sic_pkg::K_NONE,   sic_pkg::K_NONE,   sic_pkg::K_NONE,
        sic_pkg::K_NONE,   sic_pkg::K_COINC,  sic_pkg::K_NONE,
        sic_pkg::K_NONE,   sic_pkg::K_NONE,   sic_pkg::K_NONE,
        sic_pkg::K_AC_END, sic_pkg::K_SHARED, sic_pkg::K_NONE,
        sic_pkg::K_SHARED, sic_pkg::K_IMPOSS, sic_pkg::K_IMPOSS,
        sic_pkg::K_NONE,   sic_pkg::K_IMPOSS, sic_pkg::K_IMPOSS,
        sic_pkg::K_IMPOSS, sic_pkg::K_IMPOSS, sic_pkg::K_COINC,
        sic_pkg::K_IMPOSS, sic_pkg::K_COLLIN, sic_pkg::K_IMPOSS,
        sic_pkg::K_COINC,  sic_pkg::K_IMPOSS, sic_pkg::K_IMPOSS,
        sic_pkg::K_IMPOSS, sic_pkg::K_IMPOSS, sic_pkg::K_NONE,
        sic_pkg::K_IMPOSS, sic_pkg::K_IMPOSS, sic_pkg::K_SHARED,
        sic_pkg::K_NONE,   sic_pkg::K_SHARED, sic_pkg::K_AC_END,
        sic_pkg::K_NONE,   sic_pkg::K_NONE,   sic_pkg::K_NONE,
        sic_pkg::K_NONE,   sic_pkg::K_COINC,  sic_pkg::K_NONE,
        sic_pkg::K_NONE,   sic_pkg::K_NONE,   sic_pkg::K_NONE,
        sic_pkg::K_IMPOSS, sic_pkg::K_IMPOSS, sic_pkg::K_NONE,
        sic_pkg::K_IMPOSS, sic_pkg::K_IMPOSS, sic_pkg::K_SHARED,
        sic_pkg::K_NONE,   sic_pkg::K_SHARED, sic_pkg::K_AC_END,
        sic_pkg::K_IMPOSS, sic_pkg::K_IMPOSS, sic_pkg::K_NONE,
        sic_pkg::K_IMPOSS, sic_pkg::K_IMPOSS, sic_pkg::K_BD_END,
        sic_pkg::K_NONE,   sic_pkg::K_BD_END, sic_pkg::K_CROSS
    };

    sic_pkg::kind_t expected_kinds [$];
    int    mismatches = 0;
    int    waiting    = 0;
    int    checked    = 0;
    logic [7:0] seen  = '0;

    assign mismatch_count = mismatches;
    assign pending_count  = waiting;
    assign checked_count  = checked;
    assign kinds_seen     = seen;

    // Only the low COORD_BITS bits of a port count, sign-extended.
    function automatic area_t widen(input logic [sic_pkg::PORT_W-1:0] raw);
        logic signed [sic_pkg::COORD_BITS-1:0] low;
        area_t                                 wide;
        low  = raw[sic_pkg::COORD_BITS-1:0];
        wide = low;
        return wide;
    endfunction

    // Sign of the doubled area of triangle p q r, computed exactly.
    function automatic sic_pkg::sign_t turn_sign(input area_t px, py, qx, qy, rx, ry);
        area_t twice_area;
        twice_area = (qx - px) * (ry - py) - (qy - py) * (rx - px);
        if (twice_area > 0)
            return sic_pkg::SIGN_POS;
        if (twice_area < 0)
            return sic_pkg::SIGN_NEG;
        return sic_pkg::SIGN_ZERO;
    endfunction

    function automatic sic_pkg::kind_t classify_pair(
        input logic [sic_pkg::PORT_W-1:0] ax, ay, cx, cy, bx, by, dx, dy
    );
        area_t pax, pay, pcx, pcy, pbx, pby, pdx, pdy;
        sic_pkg::sign_t area_a, area_b, area_c, area_d;
        int    slot;
        pax = widen(ax); pay = widen(ay);
        pcx = widen(cx); pcy = widen(cy);
        pbx = widen(bx); pby = widen(by);
        pdx = widen(dx); pdy = widen(dy);
        area_a = turn_sign(pbx, pby, pcx, pcy, pdx, pdy);
        area_b = turn_sign(pcx, pcy, pdx, pdy, pax, pay);
        area_c = turn_sign(pdx, pdy, pax, pay, pbx, pby);
        area_d = turn_sign(pax, pay, pbx, pby, pcx, pcy);
        slot = 27 * int'(area_a) + 9 * int'(area_c) + 3 * int'(area_b) + int'(area_d);
        return KIND_BY_SIGNS[slot];
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%t checker: %s", $realtime, what);
    endtask

    // Predict on each accepted transaction, then compare each strobed result
    // against the oldest prediction.
    always @(posedge clk)
    begin : scoreboard
        sic_pkg::kind_t want;
        if (rst_n)
        begin
            if (start && !busy)
                expected_kinds.push_back(classify_pair(a_x, a_y, c_x, c_y,
                                                       b_x, b_y, d_x, d_y));
            if (done)
            begin
                if (expected_kinds.size() == 0)
                begin
                    report_mismatch($sformatf("result kind=%0d with no transaction waiting",
                                              kind));
                end
                else
                begin
                    want = expected_kinds.pop_front();
                    checked++;
                    seen[want] = 1'b1;
                    if (kind !== want)
                        report_mismatch($sformatf("result %0d: kind expected %0d (%s), got %0d",
                                                  checked, want, want.name(), kind));
                end
            end
            waiting = expected_kinds.size();
        end
    end

endmodule

>>> test/tb.sv
// Testbench top for the segment intersection classifier core.
`timescale 1ns / 1ps

module tb;

    typedef logic [sic_pkg::PORT_W-1:0] coord_word_t;

    localparam int RANDOM_ITEMS   = 1630;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int COORD_MIN      = 32'sh8000_0000;
    localparam int COORD_MAX      = 32'sh7fff_ffff;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    coord_word_t a_x = '0, a_y = '0, c_x = '0, c_y = '0;
    coord_word_t b_x = '0, b_y = '0, d_x = '0, d_y = '0;
    logic        busy;
    logic        done;
    logic [2:0]  kind;

    int          mismatch_count;
    int          pending_count;
    int          checked_count;
    logic [7:0]  kinds_seen;

    int          idle_pct   = 0;
    int          pairs_sent = 0;

    always #1 clk = ~clk;

    segment_intersection_classifier_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .a_x   (a_x),
        .a_y   (a_y),
        .c_x   (c_x),
        .c_y   (c_y),
        .b_x   (b_x),
        .b_y   (b_y),
        .d_x   (d_x),
        .d_y   (d_y),
        .done  (done),
        .kind  (kind)
    );

    segment_pair_kind_checker kind_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .a_x            (a_x),
        .a_y            (a_y),
        .c_x            (c_x),
        .c_y            (c_y),
        .b_x            (b_x),
        .b_y            (b_y),
        .d_x            (d_x),
        .d_y            (d_y),
        .done           (done),
        .kind           (kind),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count),
        .kinds_seen     (kinds_seen)
    );

    // Drive one segment pair at a falling edge, after a random idle gap,
    // and hold it until the transaction is taken.
    task automatic send_pair(input coord_word_t ax, ay, cx, cy, bx, by, dx, dy);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start = 1'b1;
        a_x = ax; a_y = ay; c_x = cx; c_y = cy;
        b_x = bx; b_y = by; d_x = dx; d_y = dy;
        do @(posedge clk); while (busy);
        pairs_sent++;
    endtask

    // One random pair. Most pairs are built to land on degenerate geometry:
    // small grids, copied endpoints, points on one line and extreme values.
    task automatic send_random_pair();
        coord_word_t pt [8];
        int          mode;
        int          ox, oy, ux, uy, pick, i;
        mode = $urandom_range(0, 99);
        if (mode < 20)
        begin
            for (i = 0; i < 8; i++)
                pt[i] = $urandom;
        end
        else if (mode < 42)
        begin
            for (i = 0; i < 8; i++)
                pt[i] = $urandom_range(0, 8) - 4;
        end
        else if (mode < 58)
        begin
            for (i = 0; i < 8; i++)
                pt[i] = $urandom_range(0, 1) ? $urandom_range(0, 16) - 8 : $urandom;
            // Copy one point onto another to make a shared or coincident end.
            case ($urandom_range(0, 5))
                0:
                begin
                    pt[4] = pt[0]; pt[5] = pt[1];
                end
                1:
                begin
                    pt[4] = pt[2]; pt[5] = pt[3];
                end
                2:
                begin
                    pt[6] = pt[0]; pt[7] = pt[1];
                end
                3:
                begin
                    pt[6] = pt[2]; pt[7] = pt[3];
                end
                4:
                begin
                    pt[2] = pt[0]; pt[3] = pt[1];
                end
                default:
                begin
                    pt[6] = pt[4]; pt[7] = pt[5];
                end
            endcase
        end
        else if (mode < 82)
        begin
            // All four points on one line, scaled from tiny to near full range,
            // then often one coordinate nudged off the line.
            ox = int'($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000;
            oy = int'($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000;
            ux = (int'($urandom_range(0, 6)) - 3) * (1 << $urandom_range(0, 26));
            uy = (int'($urandom_range(0, 6)) - 3) * (1 << $urandom_range(0, 26));
            for (i = 0; i < 4; i++)
            begin
                pick = int'($urandom_range(0, 10)) - 5;
                pt[2 * i]     = ox + pick * ux;
                pt[2 * i + 1] = oy + pick * uy;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                pick = $urandom_range(0, 7);
                pt[pick] = pt[pick] + ($urandom_range(0, 3) != 0 ?
                                       $urandom_range(0, 6) - 3 : $urandom);
            end
        end
        else
        begin
            for (i = 0; i < 8; i++)
                case ($urandom_range(0, 7))
                    0: pt[i] = COORD_MIN;
                    1: pt[i] = COORD_MAX;
                    2: pt[i] = COORD_MIN + 1;
                    3: pt[i] = COORD_MAX - 1;
                    4: pt[i] = 0;
                    5: pt[i] = -1;
                    6: pt[i] = 1;
                    default: pt[i] = $urandom;
                endcase
        end
        send_pair(pt[0], pt[1], pt[2], pt[3], pt[4], pt[5], pt[6], pt[7]);
    endtask

    // Abort when neither an input nor a result transaction happens for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d results still expected",
                 WATCHDOG_LIMIT, pending_count);
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int phase, n;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pairs: extremes, each kind of contact and degenerate input.
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                  COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                  COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                  COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_pair(0, 0, 1, 0, 0, 5, 1, 5);
        send_pair(-2, 0, 2, 0, 0, -2, 0, 2);
        send_pair(-2, 0, 2, 0, 0, 0, 0, 3);
        send_pair(0, 0, 3, 0, 0, -2, 0, 2);
        send_pair(0, 0, 2, 0, 0, 0, 0, 2);
        send_pair(0, 0, 2, 2, 4, 0, 2, 2);
        send_pair(5, 5, 5, 5, 0, 0, 2, 0);
        send_pair(1, 1, 1, 1, 0, 0, 2, 2);
        send_pair(0, 0, 4, 0, 1, 3, 1, 3);
        send_pair(0, 0, 4, 4, 2, 2, 6, 6);
        send_pair(0, 0, 1, 1, 3, 3, 5, 5);
        send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                  COORD_MIN + 1, COORD_MIN, COORD_MAX, COORD_MAX - 1);
        send_pair(COORD_MIN, 0, COORD_MAX, 0, 0, 0, 0, COORD_MAX);
        send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0, -1, -1);
        send_pair(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                  COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        send_pair(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
                  32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'hf0f0_f0f0, 32'h0f0f_0f0f);

        // Random pairs over four pacing phases: back to back, a mostly idle
        // sender, back to back again, and a lightly idle sender.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       idle_pct = 72;
                3:       idle_pct = 16;
                default: idle_pct = 0;
            endcase
            for (n = 0; n < RANDOM_ITEMS / 4; n++)
                send_random_pair();
        end

        @(negedge clk);
        start = 1'b0;
        wait (pending_count == 0);
        repeat (10) @(posedge clk);

        $display("Sent %0d segment pairs in directed and random phases, %0d results checked.",
                 pairs_sent, checked_count);
        $display("Kinds predicted at least once (bit per code): %b, mismatches: %0d",
                 kinds_seen, mismatch_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> segment_intersection_classifier_core.f
+incdir+hw/rtl
hw/rtl/sic_pkg.sv
hw/rtl/sic_area_sign.sv
hw/rtl/segment_intersection_classifier_core.sv
test/segment_pair_kind_checker.sv
test/tb.sv
